// File: design/ppc_pkg.sv
package ppc_pkg;

  // default width of the candidate value
  localparam int unsigned VALUE_BITS = 16;

  // running sum width and its saturation value
  localparam int unsigned SUM_BITS = 32;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // palindrome check applies only below this limit
  localparam int unsigned PAL_LIMIT = 10000;
  // bits needed for a number below the limit (and its digit reversal)
  localparam int unsigned PAL_BITS = 14;
  localparam int unsigned RADIX = 10;
  localparam int unsigned RADIX_DIGIT_BITS = 4;

  // smallest trial divisor
  localparam int unsigned FIRST_DIVISOR = 2;

endpackage

// File: design/prime_palindrome_classifier_core.sv
// the bit-serial divider serves every division: each trial division, and each divide by ten
//   for the digits of a prime below 10000, runs on it in turn
// worst case at 16 bits: 254 trial divisions
// throughput: one item at a time; the controller returns to idle as the result enters the
//   output register and can take the next item in the cycle after, while that result still waits
// reset: asynchronous active low, clears the running sum, the controller and the output valid
module prime_palindrome_classifier_core #(
  parameter int unsigned VALUE_BITS = ppc_pkg::VALUE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value, zero fill
  input  logic                                s_axis_tuser,  // restart
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [39:0]                         m_axis_tdata   // prime_flag, is_palindrome,
                                                             // prime_sum[31:0], sum_even,
                                                             // zero fill
);

  localparam int unsigned SumBits = ppc_pkg::SUM_BITS;
  localparam int unsigned PalBits = ppc_pkg::PAL_BITS;

  // controller state codes
  localparam logic [2:0] StIdle  = 3'd0;  // waiting for an item
  localparam logic [2:0] StPChk  = 3'd1;  // check d*d against value, launch trial
  localparam logic [2:0] StPWait = 3'd2;  // wait for the trial remainder
  localparam logic [2:0] StSum   = 3'd3;  // add prime into the running sum
  localparam logic [2:0] StDChk  = 3'd4;  // next decimal digit or final compare
  localparam logic [2:0] StDWait = 3'd5;  // wait for the divide by ten
  localparam logic [2:0] StDone  = 3'd6;  // hand result to the output register

  logic [2:0]            state_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] d_q;      // current trial divisor
  logic [VALUE_BITS:0]   dsq_q;    // d_q squared, kept by adding 2d+1 each step
  logic                  prime_q;
  logic                  pal_q;
  logic [PalBits-1:0]    rest_q;   // digits still to peel off
  logic [PalBits-1:0]    rev_q;    // digits reversed so far
  logic [SumBits-1:0]    sum_q;

  // output register
  logic                  ov_q;
  logic                  o_prime_q;
  logic                  o_pal_q;
  logic [SumBits-1:0]    o_sum_q;

  // shared divider
  logic                  div_start_w;
  logic [VALUE_BITS-1:0] div_dividend_w;
  logic [VALUE_BITS-1:0] div_divisor_w;
  logic                  div_busy_w;
  logic                  div_done_w;
  logic [VALUE_BITS-1:0] div_quot_w;
  logic [VALUE_BITS-1:0] div_rem_w;

  logic                  s_fire_w;
  logic                  m_fire_w;
  logic                  out_load_w;
  logic [SumBits:0]      sum_add_w;
  logic [PalBits-1:0]    rev_next_w;
  logic                  below_two_w;
  logic                  pal_range_w;

  assign s_axis_tready = (state_q == StIdle);
  assign s_fire_w      = s_axis_tvalid && s_axis_tready;
  assign m_fire_w      = m_axis_tvalid && m_axis_tready;
  assign out_load_w    = (state_q == StDone) && (!ov_q || m_axis_tready);

  // trial division in StPChk, divide by ten in StDChk
  assign div_start_w    = ((state_q == StPChk) && !below_two_w && (dsq_q <= {1'b0, val_q}))
                        || ((state_q == StDChk) && (rest_q != '0));
  assign div_dividend_w = (state_q == StPChk) ? val_q : VALUE_BITS'(rest_q);
  assign div_divisor_w  = (state_q == StPChk) ? d_q : VALUE_BITS'(ppc_pkg::RADIX);

  ppc_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_w),
    .dividend_i(div_dividend_w),
    .divisor_i (div_divisor_w),
    .busy_o    (div_busy_w),
    .done_o    (div_done_w),
    .quot_o    (div_quot_w),
    .rem_o     (div_rem_w)
  );

  assign below_two_w = (val_q < VALUE_BITS'(ppc_pkg::FIRST_DIVISOR));
  assign pal_range_w = ({{(SumBits + 1 - VALUE_BITS){1'b0}}, val_q}
                       < (SumBits + 1)'(ppc_pkg::PAL_LIMIT));

  // saturating add, one extra bit catches the carry
  assign sum_add_w = {1'b0, sum_q} + {{(SumBits + 1 - VALUE_BITS){1'b0}}, val_q};

  // rev * 10 + digit as shifts and adds
  assign rev_next_w = {rev_q[PalBits-4:0], 3'b000} + {rev_q[PalBits-2:0], 1'b0}
                    + PalBits'(div_rem_w[ppc_pkg::RADIX_DIGIT_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      val_q   <= '0;
      d_q     <= '0;
      dsq_q   <= '0;
      prime_q <= 1'b0;
      pal_q   <= 1'b0;
      rest_q  <= '0;
      rev_q   <= '0;
      sum_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (s_fire_w) begin
            val_q   <= s_axis_tdata[VALUE_BITS-1:0];
            d_q     <= VALUE_BITS'(ppc_pkg::FIRST_DIVISOR);
            dsq_q   <= (VALUE_BITS + 1)'(ppc_pkg::FIRST_DIVISOR * ppc_pkg::FIRST_DIVISOR);
            prime_q <= 1'b1;
            pal_q   <= 1'b0;
            if (s_axis_tuser) begin
              sum_q <= '0;
            end
            state_q <= StPChk;
          end
        end
        StPChk: begin
          if (below_two_w) begin
            prime_q <= 1'b0;
            state_q <= StSum;
          end else if (dsq_q > {1'b0, val_q}) begin
            // no divisor up to the square root: prime
            state_q <= StSum;
          end else begin
            state_q <= StPWait;
          end
        end
        StPWait: begin
          if (div_done_w) begin
            if (div_rem_w == '0) begin
              prime_q <= 1'b0;
              state_q <= StSum;
            end else begin
              d_q     <= d_q + 1'b1;
              dsq_q   <= dsq_q + {d_q, 1'b0} + 1'b1;
              state_q <= StPChk;
            end
          end
        end
        StSum: begin
          rest_q <= PalBits'(val_q);
          rev_q  <= '0;
          if (prime_q) begin
            sum_q <= sum_add_w[SumBits] ? ppc_pkg::SUM_MAX : sum_add_w[SumBits-1:0];
          end
          state_q <= (prime_q && pal_range_w) ? StDChk : StDone;
        end
        StDChk: begin
          if (rest_q == '0) begin
            pal_q   <= (rev_q == PalBits'(val_q));
            state_q <= StDone;
          end else begin
            state_q <= StDWait;
          end
        end
        StDWait: begin
          if (div_done_w) begin
            rest_q  <= PalBits'(div_quot_w);
            rev_q   <= rev_next_w;
            state_q <= StDChk;
          end
        end
        StDone: begin
          if (out_load_w) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // output register frees the controller for the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q      <= 1'b0;
      o_prime_q <= 1'b0;
      o_pal_q   <= 1'b0;
      o_sum_q   <= '0;
    end else begin
      if (out_load_w) begin
        ov_q      <= 1'b1;
        o_prime_q <= prime_q;
        o_pal_q   <= pal_q;
        o_sum_q   <= sum_q;
      end else if (m_fire_w) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {5'b00000, ~o_sum_q[0], o_sum_q, o_pal_q, o_prime_q};

`ifndef SYNTHESIS
  // a palindrome result is always a prime
  a_pal_implies_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
    else $error("palindrome flag without prime flag");

  // divider results only arrive while the controller waits for them
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_w |-> (state_q == StPWait || state_q == StDWait))
    else $error("divider finished outside a wait state");

  // a division is never launched while the divider is still busy
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_w |-> !div_busy_w)
    else $error("divider started while busy");

  // trial divisor never drops below two
  a_divisor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPChk || state_q == StPWait)
      |-> (d_q >= VALUE_BITS'(ppc_pkg::FIRST_DIVISOR)))
    else $error("trial divisor below two");

  // a saturated sum stays saturated until restart
  a_sum_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_q == ppc_pkg::SUM_MAX && !(s_fire_w && s_axis_tuser))
      |=> (sum_q == ppc_pkg::SUM_MAX))
    else $error("saturated sum left saturation");
`endif

endmodule

// File: design/ppc_div.sv
module ppc_div #(
  parameter int unsigned VALUE_BITS = ppc_pkg::VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [VALUE_BITS-1:0] rem_o
);

  localparam int unsigned CntBits = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                  busy_q;
  logic                  done_q;
  logic [CntBits-1:0]    cnt_q;
  logic [VALUE_BITS-1:0] rem_q;
  logic [VALUE_BITS-1:0] quo_q;
  logic [VALUE_BITS-1:0] dvs_q;

  // one restoring step: shift in the next dividend bit, try to subtract
  logic [VALUE_BITS:0] shift_w;
  logic [VALUE_BITS:0] diff_w;
  logic                ge_w;

  assign shift_w = {rem_q, quo_q[VALUE_BITS-1]};
  assign diff_w  = shift_w - {1'b0, dvs_q};
  assign ge_w    = shift_w >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= ge_w ? diff_w[VALUE_BITS-1:0] : shift_w[VALUE_BITS-1:0];
        quo_q <= {quo_q[VALUE_BITS-2:0], ge_w};
        if (cnt_q == CntBits'(VALUE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: bench/ppc_result_checker.sv
`timescale 1ns / 1ps
module ppc_result_checker #(
  parameter int unsigned VALUE_BITS = ppc_pkg::VALUE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   in_data_i,
  input  logic                              in_restart_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [39:0]                       out_data_i,
  output int                                errors_o,
  output int                                pending_o
);

  // result layout, lowest bit last
  typedef struct packed {
    logic [4:0]                   pad;
    logic                         even;
    logic [ppc_pkg::SUM_BITS-1:0] sum;
    logic                         palin;
    logic                         prime;
  } verdict_t;

  verdict_t                     verdict_q[$];
  logic [ppc_pkg::SUM_BITS-1:0] prime_total;
  int                           errors = 0;

  function automatic logic has_no_divisor(logic [31:0] v);
    longint unsigned d;
    if (v < ppc_pkg::FIRST_DIVISOR) return 1'b0;
    for (d = ppc_pkg::FIRST_DIVISOR; d * d <= v; d++)
      if (v % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic digits_mirror(logic [31:0] v);
    logic [31:0] rest;
    logic [31:0] rev;
    rest = v;
    rev  = '0;
    while (rest != 0) begin
      rev  = rev * ppc_pkg::RADIX + rest % ppc_pkg::RADIX;
      rest = rest / ppc_pkg::RADIX;
    end
    return rev == v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t                   want;
    verdict_t                   got;
    logic [VALUE_BITS-1:0]      v;
    logic [ppc_pkg::SUM_BITS:0] wide_total;
    if (!rst_ni) begin
      prime_total = '0;
      verdict_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        v = in_data_i[VALUE_BITS-1:0];
        if (in_restart_i) prime_total = '0;
        want       = '0;
        want.prime = has_no_divisor(32'(v));
        if (want.prime) begin
          wide_total  = {1'b0, prime_total} + v;
          prime_total = (wide_total > ppc_pkg::SUM_MAX) ? ppc_pkg::SUM_MAX
                                                         : wide_total[ppc_pkg::SUM_BITS-1:0];
          if (v < ppc_pkg::PAL_LIMIT) want.palin = digits_mirror(32'(v));
        end
        want.sum  = prime_total;
        want.even = ~prime_total[0];
        verdict_q.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (verdict_q.size() == 0) begin
          $error("result item with no item waiting: data %h", out_data_i);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.prime !== want.prime) begin
            $error("prime_flag: expected %0d, got %0d", want.prime, got.prime);
            errors++;
          end
          if (got.palin !== want.palin) begin
            $error("is_palindrome: expected %0d, got %0d", want.palin, got.palin);
            errors++;
          end
          if (got.sum !== want.sum) begin
            $error("prime_sum: expected %0d, got %0d", want.sum, got.sum);
            errors++;
          end
          if (got.even !== want.even) begin
            $error("sum_even: expected %0d, got %0d", want.even, got.even);
            errors++;
          end
        end
      end
    end
    errors_o  <= errors;
    pending_o <= verdict_q.size();
  end

endmodule

// File: bench/prime_palindrome_classifier_core_tb.sv
`timescale 1ns / 1ps
module prime_palindrome_classifier_core_tb;

  localparam int unsigned VALUE_BITS   = ppc_pkg::VALUE_BITS;
  localparam int unsigned IN_BITS      = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 77;
  localparam int unsigned MAX_WAIT     = 8;
  // drain bound covers the slowest item plus a receiver stall
  localparam int unsigned DRAIN_LIMIT  = 20000;
  // quiet cycles after the last result to catch stray result items
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam int unsigned POOL_SIZE    = 24;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_BITS-1:0]  s_axis_tdata;   // value, zero fill
  logic                s_axis_tuser;   // restart
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;   // prime_flag, is_palindrome, prime_sum, sum_even, zero fill

  int                  errors;
  int                  pending;

  // primes to keep the running sum busy: palindromes below and above the limit,
  // and the largest primes the value field can hold
  logic [VALUE_BITS-1:0] prime_pool [0:POOL_SIZE-1] = '{
    2, 3, 5, 7, 11, 101, 131, 151, 181, 191, 313, 353,
    727, 797, 919, 929, 1009, 7919, 9973, 10301, 10501, 32749, 65497, 65521
  };

  prime_palindrome_classifier_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ppc_result_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_restart_i (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop well past the slowest correct run
  initial begin
    #40_000_000;
    $display("prime_palindrome_classifier_core_tb: FAIL");
    $finish;
  end

  // wait before the next item; now and then switch to a stretch with no waits
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 11) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  bit send_quiet = 1'b0;
  bit take_quiet = 1'b0;

  // offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic restart);
    int unsigned gap;
    gap = draw_wait(send_quiet);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'(v);
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // result side: stall a random number of cycles before each result item
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(take_quiet);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // stimulus and verdict
  initial begin
    logic [VALUE_BITS-1:0] v;
    logic                  restart;
    int unsigned           waited;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: values below two, smallest primes, squares
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(4, 1'b0);
    send_item(25, 1'b0);
    send_item(49, 1'b0);
    // composite palindromes, palindromic primes
    send_item(9, 1'b0);
    send_item(121, 1'b0);
    send_item(11, 1'b0);
    send_item(929, 1'b0);
    // largest prime below the limit, palindromic prime above it
    send_item(9973, 1'b0);
    send_item(10301, 1'b0);
    // top of the value range: all ones, top bit alone, largest prime
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(65521, 1'b0);
    // restart with a non-prime leaves an even zero sum
    send_item(1, 1'b1);
    send_item(4, 1'b0);
    // restart with a prime starts the sum from that prime
    send_item(7, 1'b1);
    send_item(101, 1'b0);
    send_item(0, 1'b1);
    send_item(2, 1'b1);
    send_item(65521, 1'b0);

    // random: a mix of full range, small values, known primes and odd values
    repeat (RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       v = VALUE_BITS'($urandom);
        1:       v = VALUE_BITS'($urandom_range(0, 300));
        2:       v = prime_pool[$urandom_range(0, POOL_SIZE - 1)];
        default: v = VALUE_BITS'($urandom) | 1'b1;
      endcase
      restart = ($urandom_range(0, 7) == 0);
      send_item(v, restart);
    end
    s_axis_tvalid <= 1'b0;

    // let every expected result arrive, then watch for strays
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("prime_palindrome_classifier_core_tb: PASS");
    end else begin
      $display("prime_palindrome_classifier_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ppc_pkg.sv
design/ppc_div.sv
design/prime_palindrome_classifier_core.sv
bench/ppc_result_checker.sv
bench/prime_palindrome_classifier_core_tb.sv
